@@ design/scba_pkg.sv @@
// ----------------------------------------------------------------------------
// Size-class block allocator package
// Constants, payload types and sequencer states shared by the allocator files.
// ----------------------------------------------------------------------------
package scba_pkg;

   localparam int NUM_CLASSES     = 5;
   localparam int MIN_BLOCK       = 8;
   localparam int SLOTS_PER_CLASS = 32;

   // Each class owns a 4 KiB region of the byte address space.
   localparam int REGION_SHIFT    = 12;

   localparam int BYTES_W  = 16;
   localparam int ADDR_W   = 15;
   localparam int SIZE_OUT_W = 8;
   localparam int REGION_W = ADDR_W - REGION_SHIFT;

   localparam int LOG2_MIN_BLOCK = $clog2(MIN_BLOCK);
   localparam int SLOT_W   = $clog2(SLOTS_PER_CLASS);
   localparam int CNT_W    = $clog2(SLOTS_PER_CLASS + 1);
   localparam int CIDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CLS_REQ_W = $clog2(NUM_CLASSES + 1);
   localparam int CLS_W    = (CLS_REQ_W > REGION_W) ? CLS_REQ_W : REGION_W;
   localparam int SIZE_W   = BYTES_W + 1;
   localparam int SHAMT_W  = $clog2(LOG2_MIN_BLOCK + (1 << CLS_W) + 1);
   localparam int RAM_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
   localparam int RAM_AW   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } scba_op_type;

   typedef struct packed {
      logic                req_type;
      logic [BYTES_W-1:0]  req_bytes;
      logic [ADDR_W-1:0]   free_addr;
   } scba_req_type;

   typedef struct packed {
      logic                  granted;
      logic [ADDR_W-1:0]     block_addr;
      logic [SIZE_OUT_W-1:0] block_bytes;
   } scba_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD,
      ST_FREE,
      ST_ADDR,
      ST_RESP
   } scba_state_type;

endpackage

@@ design/scba_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/size_class_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Size-class block allocator
// Power-of-two size classes, each with a bump counter and a FIFO of freed
// slots kept in a shared RAM. One request is handled at a time by a small
// sequencer around a shared shifter.
// ----------------------------------------------------------------------------
// From request transfer to response valid: a free passes ST_FREE and ST_ADDR; an
// allocate passes ST_SCAN, then ST_ADDR from the bump counter or ST_RD and ST_ADDR
// from the freed-slot FIFO (one extra RAM read), with one ST_SCAN step for each class
// stepped over by the class scan. Failures finish when the check fails.
// Throughput: one request at a time; a new request is taken the cycle after
// the response transfer. Reset clears all counters and FIFO pointers at once.
module size_class_block_allocator_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  scba_pkg::scba_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output scba_pkg::scba_rsp_type rsp_data
);

   scba_pkg::scba_state_type state_ff, state_in;
   scba_pkg::scba_req_type   req_ff, req_in;
   scba_pkg::scba_rsp_type   rsp_ff, rsp_in;

   logic [scba_pkg::CLS_W-1:0]  cls_ff, cls_in;
   logic [scba_pkg::SLOT_W-1:0] slot_ff, slot_in;

   logic [scba_pkg::CNT_W-1:0]  bump_count_ff [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::CNT_W-1:0]  bump_count_in [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::SLOT_W-1:0] fifo_head_ff  [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::SLOT_W-1:0] fifo_head_in  [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::SLOT_W-1:0] fifo_tail_ff  [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::SLOT_W-1:0] fifo_tail_in  [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::CNT_W-1:0]  fifo_count_ff [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::CNT_W-1:0]  fifo_count_in [scba_pkg::NUM_CLASSES];

   logic                         req_fire;
   logic                         cls_ok;
   logic [scba_pkg::CIDX_W-1:0]  cls_idx;
   logic [scba_pkg::SIZE_W-1:0]  size_cur;
   logic                         fits;
   logic [scba_pkg::CNT_W-1:0]   bump_cur;
   logic [scba_pkg::SLOT_W-1:0]  head_cur;
   logic [scba_pkg::SLOT_W-1:0]  tail_cur;
   logic [scba_pkg::CNT_W-1:0]   count_cur;
   logic                         has_bump;
   logic                         has_fifo;
   logic                         fifo_full;

   // Shared shifter: slot offset to slot number on a free, slot number to
   // byte offset when forming the block address.
   logic                         shift_left;
   logic [scba_pkg::SHAMT_W-1:0] shift_amt;
   logic [scba_pkg::ADDR_W-1:0]  shift_opnd;
   logic [scba_pkg::ADDR_W-1:0]  shift_res;
   logic                         slot_ok;
   logic [scba_pkg::ADDR_W-1:0]  block_addr;

   logic                         ram_we;
   logic                         ram_re;
   logic [scba_pkg::RAM_AW-1:0]  ram_wr_addr;
   logic [scba_pkg::RAM_AW-1:0]  ram_rd_addr;
   logic [scba_pkg::SLOT_W-1:0]  ram_rd_data;

   assign req_ready = (state_ff == scba_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == scba_pkg::ST_RESP);
   assign rsp_data  = rsp_ff;
   assign req_fire  = req_valid && req_ready;

   assign cls_ok   = (cls_ff < scba_pkg::CLS_W'(scba_pkg::NUM_CLASSES));
   assign cls_idx  = cls_ok ? cls_ff[scba_pkg::CIDX_W-1:0] : '0;
   assign size_cur = scba_pkg::SIZE_W'(scba_pkg::SIZE_W'(scba_pkg::MIN_BLOCK) << cls_ff);
   assign fits     = (size_cur >= scba_pkg::SIZE_W'(req_ff.req_bytes));

   assign bump_cur  = bump_count_ff[cls_idx];
   assign head_cur  = fifo_head_ff[cls_idx];
   assign tail_cur  = fifo_tail_ff[cls_idx];
   assign count_cur = fifo_count_ff[cls_idx];
   assign has_bump  = (bump_cur < scba_pkg::CNT_W'(scba_pkg::SLOTS_PER_CLASS));
   assign has_fifo  = (count_cur != '0);
   assign fifo_full = (count_cur >= scba_pkg::CNT_W'(scba_pkg::SLOTS_PER_CLASS));

   assign shift_left = (state_ff == scba_pkg::ST_ADDR);
   assign shift_amt  = scba_pkg::SHAMT_W'(scba_pkg::LOG2_MIN_BLOCK) +
                       scba_pkg::SHAMT_W'(cls_ff);
   assign shift_opnd = shift_left ?
                       scba_pkg::ADDR_W'(slot_ff) :
                       scba_pkg::ADDR_W'(req_ff.free_addr[scba_pkg::REGION_SHIFT-1:0]);
   assign shift_res  = shift_left ? (shift_opnd << shift_amt) : (shift_opnd >> shift_amt);
   assign slot_ok    = (shift_res < scba_pkg::ADDR_W'(scba_pkg::SLOTS_PER_CLASS));
   assign block_addr = scba_pkg::ADDR_W'(scba_pkg::ADDR_W'(cls_ff) << scba_pkg::REGION_SHIFT)
                       + shift_res;

   assign ram_wr_addr = scba_pkg::RAM_AW'(cls_idx) * scba_pkg::RAM_AW'(scba_pkg::SLOTS_PER_CLASS)
                        + scba_pkg::RAM_AW'(tail_cur);
   assign ram_rd_addr = scba_pkg::RAM_AW'(cls_idx) * scba_pkg::RAM_AW'(scba_pkg::SLOTS_PER_CLASS)
                        + scba_pkg::RAM_AW'(head_cur);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scba_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.req_type == scba_pkg::REQ_FREE) ?
                          scba_pkg::ST_FREE : scba_pkg::ST_SCAN;
            end
         end
         scba_pkg::ST_SCAN: begin
            if (!cls_ok) begin
               state_in = scba_pkg::ST_RESP;
            end else if (fits && has_bump) begin
               state_in = scba_pkg::ST_ADDR;
            end else if (fits && has_fifo) begin
               state_in = scba_pkg::ST_RD;
            end
         end
         scba_pkg::ST_RD: begin
            state_in = scba_pkg::ST_ADDR;
         end
         scba_pkg::ST_FREE: begin
            if (!cls_ok || !slot_ok || fifo_full) begin
               state_in = scba_pkg::ST_RESP;
            end else begin
               state_in = scba_pkg::ST_ADDR;
            end
         end
         scba_pkg::ST_ADDR: begin
            state_in = scba_pkg::ST_RESP;
         end
         scba_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = scba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scba_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath controls and next values.
   always_comb begin
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      cls_in        = cls_ff;
      slot_in       = slot_ff;
      bump_count_in = bump_count_ff;
      fifo_head_in  = fifo_head_ff;
      fifo_tail_in  = fifo_tail_ff;
      fifo_count_in = fifo_count_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      case (state_ff)
         scba_pkg::ST_IDLE: begin
            if (req_fire) begin
               req_in = req_data;
               if (req_data.req_type == scba_pkg::REQ_FREE) begin
                  cls_in = scba_pkg::CLS_W'(req_data.free_addr[scba_pkg::ADDR_W-1:
                                                               scba_pkg::REGION_SHIFT]);
               end else begin
                  cls_in = '0;
               end
            end
         end
         scba_pkg::ST_SCAN: begin
            // Block sizes grow with the class, so once a class fits every
            // later class fits too and one pass covers both searches.
            if (!cls_ok) begin
               rsp_in = '0;
            end else if (fits && has_bump) begin
               slot_in = bump_cur[scba_pkg::SLOT_W-1:0];
               bump_count_in[cls_idx] = bump_cur + 1'b1;
            end else if (fits && has_fifo) begin
               ram_re = 1'b1;
               fifo_head_in[cls_idx] =
                  (head_cur == scba_pkg::SLOT_W'(scba_pkg::SLOTS_PER_CLASS - 1)) ?
                  '0 : head_cur + 1'b1;
               fifo_count_in[cls_idx] = count_cur - 1'b1;
            end else begin
               cls_in = cls_ff + 1'b1;
            end
         end
         scba_pkg::ST_RD: begin
            slot_in = ram_rd_data;
         end
         scba_pkg::ST_FREE: begin
            if (!cls_ok || !slot_ok || fifo_full) begin
               rsp_in = '0;
            end else begin
               ram_we  = 1'b1;
               slot_in = shift_res[scba_pkg::SLOT_W-1:0];
               fifo_tail_in[cls_idx] =
                  (tail_cur == scba_pkg::SLOT_W'(scba_pkg::SLOTS_PER_CLASS - 1)) ?
                  '0 : tail_cur + 1'b1;
               fifo_count_in[cls_idx] = count_cur + 1'b1;
            end
         end
         scba_pkg::ST_ADDR: begin
            rsp_in.granted     = 1'b1;
            rsp_in.block_addr  = block_addr;
            rsp_in.block_bytes = size_cur[scba_pkg::SIZE_OUT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scba_pkg::ST_IDLE;
         bump_count_ff <= '{default: '0};
         fifo_head_ff  <= '{default: '0};
         fifo_tail_ff  <= '{default: '0};
         fifo_count_ff <= '{default: '0};
      end else begin
         state_ff      <= state_in;
         bump_count_ff <= bump_count_in;
         fifo_head_ff  <= fifo_head_in;
         fifo_tail_ff  <= fifo_tail_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      cls_ff  <= cls_in;
      slot_ff <= slot_in;
   end

   scba_ram #(
      .WIDTH (scba_pkg::SLOT_W),
      .DEPTH (scba_pkg::RAM_DEPTH)
   ) u_freed_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (slot_in),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

@@ design/scba_checker.sv @@
// ----------------------------------------------------------------------------
// Size-class block allocator checker
// Port-level properties of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module scba_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  scba_pkg::scba_rsp_type rsp_data
);

   // A response that is not taken holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // One request in flight: no new request while a response is offered.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |->
         rsp_data.block_addr == '0 && rsp_data.block_bytes == '0)
      else $error("refused response carries a nonzero address or size");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted |->
         rsp_data.block_addr[scba_pkg::ADDR_W-1:scba_pkg::REGION_SHIFT] <
         scba_pkg::NUM_CLASSES)
      else $error("granted block lies outside every class region");

endmodule

bind size_class_block_allocator_unit scba_checker u_scba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/sv/tb_size_class_block_allocator_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Size-class block allocator testbench
// Drives allocate and free requests through the request channel and checks
// every response against an in-bench model of the per-class bump counters
// and freed-slot queues. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_size_class_block_allocator_unit;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS = 130;

   // Tracks allocator state and the queue of responses it still owes.
   class block_ledger;
      bit [scba_pkg::CNT_W-1:0]  bumped [scba_pkg::NUM_CLASSES];
      bit [scba_pkg::SLOT_W-1:0] freed [scba_pkg::NUM_CLASSES][scba_pkg::SLOTS_PER_CLASS];
      int                        free_rd [scba_pkg::NUM_CLASSES];
      int                        free_wr [scba_pkg::NUM_CLASSES];
      int                        free_fill [scba_pkg::NUM_CLASSES];
      scba_pkg::scba_rsp_type    owed_rsps [$];
      int                        mismatches;

      function new();
         for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
            bumped[c] = '0;
            free_rd[c] = 0;
            free_wr[c] = 0;
            free_fill[c] = 0;
         end
         mismatches = 0;
      endfunction

      function scba_pkg::scba_rsp_type grant(int cls, int slot);
         scba_pkg::scba_rsp_type r;
         int                     bytes;
         bytes = scba_pkg::MIN_BLOCK << cls;
         r.granted = 1'b1;
         r.block_addr = scba_pkg::ADDR_W'((cls << scba_pkg::REGION_SHIFT) + slot * bytes);
         r.block_bytes = scba_pkg::SIZE_OUT_W'(bytes);
         return r;
      endfunction

      function scba_pkg::scba_rsp_type allocate(bit [scba_pkg::BYTES_W-1:0] want);
         int cls;
         int slot;
         cls = 0;
         while (cls < scba_pkg::NUM_CLASSES && (scba_pkg::MIN_BLOCK << cls) < want)
            cls++;
         for (; cls < scba_pkg::NUM_CLASSES; cls++) begin
            if (bumped[cls] < scba_pkg::SLOTS_PER_CLASS) begin
               slot = bumped[cls];
               bumped[cls]++;
               return grant(cls, slot);
            end else if (free_fill[cls] > 0) begin
               slot = freed[cls][free_rd[cls]];
               free_rd[cls] = (free_rd[cls] + 1) % scba_pkg::SLOTS_PER_CLASS;
               free_fill[cls]--;
               return grant(cls, slot);
            end
         end
         return '0;
      endfunction

      function scba_pkg::scba_rsp_type release_block(bit [scba_pkg::ADDR_W-1:0] addr);
         int cls;
         int slot;
         cls = addr >> scba_pkg::REGION_SHIFT;
         if (cls >= scba_pkg::NUM_CLASSES)
            return '0;
         slot = (addr & ((1 << scba_pkg::REGION_SHIFT) - 1)) / (scba_pkg::MIN_BLOCK << cls);
         if (slot >= scba_pkg::SLOTS_PER_CLASS || free_fill[cls] >= scba_pkg::SLOTS_PER_CLASS)
            return '0;
         freed[cls][free_wr[cls]] = scba_pkg::SLOT_W'(slot);
         free_wr[cls] = (free_wr[cls] + 1) % scba_pkg::SLOTS_PER_CLASS;
         free_fill[cls]++;
         return grant(cls, slot);
      endfunction

      function void note_request(scba_pkg::scba_req_type req);
         if (req.req_type == scba_pkg::REQ_FREE)
            owed_rsps.push_back(release_block(req.free_addr));
         else
            owed_rsps.push_back(allocate(req.req_bytes));
      endfunction

      function void check_response(scba_pkg::scba_rsp_type got);
         scba_pkg::scba_rsp_type want;
         if (owed_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with none outstanding: granted=%0d addr=%0h bytes=%0d",
                        $time, got.granted, got.block_addr, got.block_bytes);
            return;
         end
         want = owed_rsps.pop_front();
         if (got.granted !== want.granted || got.block_addr !== want.block_addr ||
             got.block_bytes !== want.block_bytes) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: granted/addr/bytes expected %0d/%0h/%0d, got %0d/%0h/%0d",
                        $time, want.granted, want.block_addr, want.block_bytes,
                        got.granted, got.block_addr, got.block_bytes);
         end
      endfunction

      function int pending();
         return owed_rsps.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   scba_pkg::scba_req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   scba_pkg::scba_rsp_type rsp_data;

   block_ledger ledger;
   int          send_idle_pct;
   int          rsp_idle_pct;
   int          hold_requests;
   int          holds_served;
   int          hold_left;
   int          cycles;

   size_class_block_allocator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      hold_requests = 0;
      holds_served = 0;
      hold_left = 0;
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      ledger = new();
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Both transfers are observed on the same edge, requests first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            ledger.note_request(req_data);
         if (rsp_valid && rsp_ready)
            ledger.check_response(rsp_data);
      end
   end

   // Response back-pressure, with an occasional long hold on request.
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic scba_pkg::scba_req_type make_req(scba_pkg::scba_op_type op, int bytes,
                                                       int addr);
      scba_pkg::scba_req_type r;
      r.req_type = op;
      r.req_bytes = scba_pkg::BYTES_W'(bytes);
      r.free_addr = scba_pkg::ADDR_W'(addr);
      return r;
   endfunction

   // Mostly well-formed allocates and frees inside the class regions,
   // with a share of fully random noise.
   function automatic scba_pkg::scba_req_type random_req(int alloc_pct);
      int pick;
      int cls;
      int bytes;
      int addr;
      pick = $urandom_range(99);
      if (pick >= 90)
         return make_req(scba_pkg::scba_op_type'($urandom_range(1)), $urandom_range(65535),
                         $urandom_range(32767));
      if (pick < alloc_pct * 9 / 10) begin
         case ($urandom_range(9))
            7, 8: bytes = (scba_pkg::MIN_BLOCK << $urandom_range(scba_pkg::NUM_CLASSES - 1)) +
                          $urandom_range(1);
            9: bytes = $urandom_range(65535);
            default: bytes = $urandom_range(scba_pkg::MIN_BLOCK << (scba_pkg::NUM_CLASSES - 1));
         endcase
         return make_req(scba_pkg::REQ_ALLOC, bytes, $urandom_range(32767));
      end
      cls = $urandom_range(scba_pkg::NUM_CLASSES - 1);
      addr = (cls << scba_pkg::REGION_SHIFT) +
             $urandom_range(scba_pkg::SLOTS_PER_CLASS - 1) * (scba_pkg::MIN_BLOCK << cls);
      if ($urandom_range(1))
         addr += $urandom_range((scba_pkg::MIN_BLOCK << cls) - 1);
      return make_req(scba_pkg::REQ_FREE, $urandom_range(65535), addr);
   endfunction

   task automatic send_request(scba_pkg::scba_req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // The last request was already transferred, so valid drops before waiting.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int alloc_pct, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      rsp_idle_pct = r_idle;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i == PHASE_ITEMS / 4)
            hold_requests++;
         if (i == PHASE_ITEMS / 2)
            wait_for_drain();
         send_request(random_req(alloc_pct));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      rsp_idle_pct = 86;

      // Class boundaries, zero bytes, oversize requests.
      send_request(make_req(scba_pkg::REQ_ALLOC, 0, 32767));
      send_request(make_req(scba_pkg::REQ_ALLOC, 1, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 8, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 9, 21845));
      send_request(make_req(scba_pkg::REQ_ALLOC, 16, 10922));
      send_request(make_req(scba_pkg::REQ_ALLOC, 17, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 32, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 33, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 64, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 65, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 128, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 129, 0));
      send_request(make_req(scba_pkg::REQ_ALLOC, 65535, 32767));
      // Misaligned free, double free, slot never handed out,
      // slot and region out of range.
      send_request(make_req(scba_pkg::REQ_FREE, 65535, 3));
      send_request(make_req(scba_pkg::REQ_FREE, 0, 3));
      send_request(make_req(scba_pkg::REQ_FREE, 0, 'h1011));
      send_request(make_req(scba_pkg::REQ_FREE, 43690, 'h4FFF));
      send_request(make_req(scba_pkg::REQ_FREE, 0, 'h0100));
      send_request(make_req(scba_pkg::REQ_FREE, 0, 'h0FFF));
      send_request(make_req(scba_pkg::REQ_FREE, 0, 'h5000));
      send_request(make_req(scba_pkg::REQ_FREE, 0, 'h7FFF));

      run_phase(60, 13, 86);
      run_phase(30, 86, 13);
      run_phase(45, 0, 0);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ size_class_block_allocator_unit.f @@
design/scba_pkg.sv
design/scba_ram.sv
design/size_class_block_allocator_unit.sv
design/scba_checker.sv
tb/sv/tb_size_class_block_allocator_unit.sv
